// File: hdl/sorted_date_event_table_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted date event table
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_DATE_EVENT_TABLE_CORE_ASSERT_SVH
`define SORTED_DATE_EVENT_TABLE_CORE_ASSERT_SVH

// Same-cycle implication
`define SDET_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdet assertion failed");

// Next-cycle implication
`define SDET_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdet assertion failed");

`endif

// File: hdl/sdet_pkg.sv
// ----------------------------------------------------------------------------
// sdet_pkg
// Types and constants for the sorted date event table.
// ----------------------------------------------------------------------------
package sdet_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned TAG_W    = 16;
  // date key is {year, month, day}, which is also the low part of an entry
  localparam int unsigned KEY_W    = DAY_W + MONTH_W + YEAR_W;
  localparam int unsigned ENTRY_W  = KEY_W + TAG_W;
  localparam int unsigned TDATA_W  = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_LISTED    = 3'd3,
    STAT_NONE      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_DEL_RD,
    S_DEL_CHK,
    S_QRY_RD,
    S_QRY_CHK,
    S_EMIT
  } state_t;

endpackage

// File: hdl/sorted_date_event_table_core.sv
// ----------------------------------------------------------------------------
// sorted_date_event_table_core
// Table of dated entries kept sorted by (year, month, day).
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transfer. in_tuser carries the opcode (insert,
//           delete by date, list on or after date); in_tdata the date and tag.
//   out_* : results. out_tuser is the status, out_tdata the listed entry
//           (zero unless listed), out_tlast marks the final result of a command.
// Operation: one table walk per command through a single date comparator and
//   a one-read one-write entry memory. An insert into a full table goes
//   straight to emit and an unused opcode gives no result. Insert walks down,
//   moving larger entries up a slot; delete walks all entries held; query
//   lists the first entry on or after the date and all later ones, or none.
//   in_tready is high only while the sequencer is idle; the next command is
//   taken while the last result still sits in the output register.
// Reset: entry count cleared, output empty; the memory holds no reset value
//   and no clearing pass is run, only entries below the count are read.
// Stall: when out_tready is low the sequencer holds in its emit step until
//   the output register frees up; nothing is dropped.
// ----------------------------------------------------------------------------
`include "sorted_date_event_table_core_assert.svh"

module sorted_date_event_table_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [sdet_pkg::TDATA_W-1:0] in_tdata,   // day, month, year, tag
  input  logic [sdet_pkg::OP_W-1:0]    in_tuser,   // opcode
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [sdet_pkg::TDATA_W-1:0] out_tdata,  // day, month, year, tag
  output logic [sdet_pkg::STATUS_W-1:0] out_tuser, // status
  output logic                         out_tlast
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  logic [sdet_pkg::ENTRY_W-1:0] mem [CAPACITY];

  sdet_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  logic             found_r, found_nxt;
  logic [sdet_pkg::ENTRY_W-1:0] req_r, req_nxt;
  sdet_pkg::status_t res_status_r, res_status_nxt;
  logic [sdet_pkg::ENTRY_W-1:0] res_data_r, res_data_nxt;
  logic             res_last_r, res_last_nxt;

  logic                         out_tvalid_r, out_tvalid_nxt;
  logic [sdet_pkg::ENTRY_W-1:0] out_data_r, out_data_nxt;
  sdet_pkg::status_t            out_status_r, out_status_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [sdet_pkg::ENTRY_W-1:0] mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [sdet_pkg::ENTRY_W-1:0] rd_data_r;

  logic in_xfer, out_free;
  logic key_gt, key_eq;
  logic [CW-1:0] k_inc, k_dec;

  assign in_tready = (state_r == sdet_pkg::S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign k_inc     = k_r + 1'b1;
  assign k_dec     = k_r - 1'b1;

  // the one shared compare unit: stored date against requested date
  assign key_gt = rd_data_r[sdet_pkg::KEY_W-1:0] > req_r[sdet_pkg::KEY_W-1:0];
  assign key_eq = rd_data_r[sdet_pkg::KEY_W-1:0] == req_r[sdet_pkg::KEY_W-1:0];

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sdet_pkg::S_IDLE: begin
        if (in_xfer) begin
          priority case (in_tuser)
            sdet_pkg::OP_INSERT: begin
              state_nxt = (count_r == CW'(CAPACITY)) ? sdet_pkg::S_EMIT
                                                     : sdet_pkg::S_INS_RD;
            end
            sdet_pkg::OP_DELETE: state_nxt = sdet_pkg::S_DEL_RD;
            sdet_pkg::OP_QUERY:  state_nxt = sdet_pkg::S_QRY_RD;
            default:             state_nxt = sdet_pkg::S_IDLE;
          endcase
        end
      end
      sdet_pkg::S_INS_RD: begin
        state_nxt = (k_r == '0) ? sdet_pkg::S_EMIT : sdet_pkg::S_INS_CHK;
      end
      sdet_pkg::S_INS_CHK: begin
        state_nxt = key_gt ? sdet_pkg::S_INS_RD : sdet_pkg::S_EMIT;
      end
      sdet_pkg::S_DEL_RD: begin
        state_nxt = (k_r == count_r) ? sdet_pkg::S_EMIT : sdet_pkg::S_DEL_CHK;
      end
      sdet_pkg::S_DEL_CHK: state_nxt = sdet_pkg::S_DEL_RD;
      sdet_pkg::S_QRY_RD: begin
        state_nxt = (k_r == count_r) ? sdet_pkg::S_EMIT : sdet_pkg::S_QRY_CHK;
      end
      sdet_pkg::S_QRY_CHK: begin
        state_nxt = key_gt || key_eq ? sdet_pkg::S_EMIT : sdet_pkg::S_QRY_RD;
      end
      sdet_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = res_last_r ? sdet_pkg::S_IDLE : sdet_pkg::S_QRY_RD;
        end
      end
      default: state_nxt = sdet_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_nxt      = count_r;
    k_nxt          = k_r;
    found_nxt      = found_r;
    req_nxt        = req_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_last_nxt   = res_last_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = k_r[AW-1:0];
    mem_wdata      = req_r;
    mem_raddr      = k_r[AW-1:0];

    unique case (state_r)
      sdet_pkg::S_IDLE: begin
        if (in_xfer) begin
          req_nxt        = in_tdata[sdet_pkg::ENTRY_W-1:0];
          found_nxt      = 1'b0;
          res_data_nxt   = '0;
          res_last_nxt   = 1'b1;
          res_status_nxt = sdet_pkg::STAT_FULL;
          // insert walks down from the top, the others walk up from zero
          k_nxt = (in_tuser == sdet_pkg::OP_INSERT) ? count_r : '0;
        end
      end
      sdet_pkg::S_INS_RD: begin
        mem_raddr = k_dec[AW-1:0];
        if (k_r == '0) begin
          mem_we         = 1'b1;
          count_nxt      = count_r + 1'b1;
          res_status_nxt = sdet_pkg::STAT_OK;
        end
      end
      sdet_pkg::S_INS_CHK: begin
        mem_we = 1'b1;
        if (key_gt) begin
          mem_wdata = rd_data_r;
          k_nxt     = k_dec;
        end else begin
          count_nxt      = count_r + 1'b1;
          res_status_nxt = sdet_pkg::STAT_OK;
        end
      end
      sdet_pkg::S_DEL_RD: begin
        if (k_r == count_r) begin
          if (found_r) begin
            count_nxt      = count_r - 1'b1;
            res_status_nxt = sdet_pkg::STAT_OK;
          end else begin
            res_status_nxt = sdet_pkg::STAT_NOT_FOUND;
          end
        end
      end
      sdet_pkg::S_DEL_CHK: begin
        // after the match every entry moves down one slot
        if (found_r) begin
          mem_we    = 1'b1;
          mem_waddr = k_dec[AW-1:0];
          mem_wdata = rd_data_r;
        end else if (key_eq) begin
          found_nxt = 1'b1;
        end
        k_nxt = k_inc;
      end
      sdet_pkg::S_QRY_RD: begin
        if (k_r == count_r) begin
          res_status_nxt = sdet_pkg::STAT_NONE;
          res_data_nxt   = '0;
          res_last_nxt   = 1'b1;
        end
      end
      sdet_pkg::S_QRY_CHK: begin
        // table is sorted, so once one entry qualifies all later ones do
        if (key_gt || key_eq) begin
          res_status_nxt = sdet_pkg::STAT_LISTED;
          res_data_nxt   = rd_data_r;
          res_last_nxt   = (k_inc == count_r);
        end
        k_nxt = k_inc;
      end
      sdet_pkg::S_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = res_data_r;
          out_status_nxt = res_status_r;
          out_last_nxt   = res_last_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sdet_pkg::S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    found_r      <= found_nxt;
    req_r        <= req_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_last_r   <= res_last_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(sdet_pkg::TDATA_W - sdet_pkg::ENTRY_W){1'b0}}, out_data_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  `SDET_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(CAPACITY))
  `SDET_ASSERT_NEXT(a_cmd_leaves_idle,
                    in_xfer && (in_tuser == sdet_pkg::OP_INSERT ||
                                in_tuser == sdet_pkg::OP_DELETE ||
                                in_tuser == sdet_pkg::OP_QUERY),
                    state_r != sdet_pkg::S_IDLE)
  `SDET_ASSERT_NEXT(a_insert_grows,
                    state_r == sdet_pkg::S_INS_CHK && !key_gt,
                    count_r == $past(count_r) + 1'b1)
  `SDET_ASSERT_SAME(a_load_from_emit, $rose(out_tvalid_r),
                    $past(state_r) == sdet_pkg::S_EMIT)

endmodule
